FILE: hdl/fbpa_pkg.sv
// Shared types and codes for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic       action;
    logic [3:0] block_index;
  } in_word_t;

  typedef struct packed {
    logic [3:0] granted_index;
    logic [1:0] status;
    logic [4:0] free_left;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;        // capture request, restart scan
    logic       fs_rd;        // read top of free stack
    logic       scan;         // issue next used-list read
    logic       mv_rd;        // read last used-list entry
    logic       commit_alloc; // pop free stack, append used list
    logic       commit_free;  // push free stack, compact used list
    logic       emit;         // load output register
    logic [1:0] code;         // status of emitted word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pool_empty;
    logic stack_full;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/fbpa_datapath.sv
// Datapath: free stack, used list, counters, scan pipeline and output register.
`timescale 1ns / 1ps

module fbpa_datapath #(
  parameter int POOL_SIZE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpa_pkg::in_word_t in_word_i,
  input  fbpa_pkg::cmd_t     cmd_i,
  output fbpa_pkg::sts_t     sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output fbpa_pkg::out_word_t out_word_o
);

  localparam int IW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int CMPW = (IW > 4) ? IW : 4;

  logic [IW-1:0] free_stack [POOL_SIZE];
  logic [IW-1:0] used_list  [POOL_SIZE];

  logic [CW-1:0] free_depth_q, used_depth_q, min_q;
  logic [CW-1:0] scan_q, pend_idx_q;
  logic          pend_q, done_q, out_valid_q;
  logic [3:0]    want_q;
  logic [IW-1:0] fs_rd_q, used_rd_q;
  logic          fs_fresh_q;
  fbpa_pkg::out_word_t out_q;

  logic [CW-1:0] top;
  logic [CW-1:0] last;
  logic [IW-1:0] got;
  logic [IW-1:0] ul_addr;
  logic          ul_rd_en;
  logic          scan_live;

  assign top       = free_depth_q - CW'(1);
  assign last      = used_depth_q - CW'(1);
  assign got       = fs_fresh_q ? top[IW-1:0] : fs_rd_q;
  assign scan_live = scan_q < used_depth_q;
  assign ul_addr   = cmd_i.mv_rd ? last[IW-1:0] : scan_q[IW-1:0];
  assign ul_rd_en  = cmd_i.mv_rd || (cmd_i.scan && scan_live);

  assign sts_o.pool_empty = (free_depth_q == '0) || (used_depth_q >= CW'(POOL_SIZE));
  assign sts_o.stack_full = free_depth_q >= CW'(POOL_SIZE);
  assign sts_o.scan_hit   = pend_q && (CMPW'(used_rd_q) == CMPW'(want_q));
  assign sts_o.scan_done  = done_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_depth_q <= CW'(POOL_SIZE);
      used_depth_q <= '0;
      min_q        <= CW'(POOL_SIZE);
      scan_q       <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        scan_q <= '0;
        pend_q <= 1'b0;
        done_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (scan_live) begin
          scan_q <= scan_q + CW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
      if (cmd_i.commit_alloc) begin
        free_depth_q <= top;
        used_depth_q <= used_depth_q + CW'(1);
        if (top < min_q) begin
          min_q <= top;
        end
      end else if (cmd_i.commit_free) begin
        free_depth_q <= free_depth_q + CW'(1);
        used_depth_q <= last;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memories and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      want_q <= in_word_i.block_index;
    end
    if (cmd_i.fs_rd) begin
      fs_rd_q    <= free_stack[top[IW-1:0]];
      fs_fresh_q <= top < min_q;
    end
    if (ul_rd_en) begin
      used_rd_q <= used_list[ul_addr];
    end
    if (cmd_i.scan && scan_live) begin
      pend_idx_q <= scan_q;
    end
    if (cmd_i.commit_alloc) begin
      used_list[used_depth_q[IW-1:0]] <= got;
    end else if (cmd_i.commit_free) begin
      used_list[pend_idx_q[IW-1:0]] <= used_rd_q;
      free_stack[free_depth_q[IW-1:0]] <= IW'(want_q);
    end
    if (cmd_i.emit) begin
      out_q.status <= cmd_i.code;
      if (cmd_i.commit_alloc) begin
        out_q.granted_index <= 4'(got);
        out_q.free_left     <= 5'(top);
      end else if (cmd_i.commit_free) begin
        out_q.granted_index <= want_q;
        out_q.free_left     <= 5'(free_depth_q + CW'(1));
      end else begin
        out_q.granted_index <= '0;
        out_q.free_left     <= 5'(free_depth_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hdl/fbpa_ctrl.sv
// Controller: sequences allocate and free requests over the datapath.
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  output logic           in_ready_o,
  input  fbpa_pkg::sts_t sts_i,
  output fbpa_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_WR,
    S_ERR_EMPTY,
    S_ERR_NA
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = fbpa_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (in_action_i == fbpa_pkg::ACT_ALLOC) begin
            if (sts_i.pool_empty) begin
              state_d = S_ERR_EMPTY;
            end else begin
              cmd_o.fs_rd = 1'b1;
              state_d     = S_ALLOC_WR;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          if (sts_i.stack_full) begin
            state_d = S_ERR_NA;
          end else begin
            cmd_o.mv_rd = 1'b1;
            state_d     = S_FREE_WR;
          end
        end else if (sts_i.scan_done) begin
          state_d = S_ERR_NA;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.commit_alloc = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_FREE_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.commit_free = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_ERR_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = fbpa_pkg::ST_EMPTY;
          state_d    = S_IDLE;
        end
      end
      S_ERR_NA: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = fbpa_pkg::ST_NOT_ALLOC;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator.
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Each input word either allocates a block
// (action 0) or frees the block named by block_index (action 1); each gives
// exactly one output word with the granted or freed index, a status (ok, pool
// empty, not allocated) and the free count left. Free blocks sit on a LIFO
// stack, so right after reset the grants come out POOL_SIZE-1, POOL_SIZE-2,
// and so on. Granted blocks sit on an unordered used list; a free walks it
// one entry per cycle through the single read port of the used-list memory
// and, on a hit, fills the hole with the last entry. An allocate goes from
// acceptance through S_ALLOC_WR to the output register; a free first walks
// up to used_depth used-list entries, POOL_SIZE at most, so it takes longer.
// One request is in flight at a time: in_ready_o is high only while the
// controller is idle. The result sits in an output register, so a word that
// is still waiting downstream does not block acceptance of the next request;
// that request only holds in its final step until the register frees up.
// No clearing pass is needed after reset: a low-water mark on the free stack
// stands in for the reset contents of the stack memory.

module fixed_block_pool_allocator_top #(
  parameter int POOL_SIZE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbpa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fbpa_pkg::out_word_t out_word_o
);

  fbpa_pkg::cmd_t cmd;
  fbpa_pkg::sts_t sts;

  // Sequence each request
  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_word_i.action),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold pool state and drive the result word
  fbpa_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hdl/fbpa_checker.sv
// Port-level checks for the fixed block pool allocator, bound to the top.
`timescale 1ns / 1ps

module fbpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fbpa_pkg::out_word_t out_word_o
);

  // One request at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Errors report a zero index
  a_err_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != fbpa_pkg::ST_OK |->
      out_word_o.granted_index == 4'd0)
    else $error("error word with nonzero index");

  // Empty pool reports no free blocks
  a_empty_zero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == fbpa_pkg::ST_EMPTY |->
      out_word_o.free_left == 5'd0)
    else $error("pool empty with free blocks left");

  // Status code is always defined
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status == fbpa_pkg::ST_OK ||
      out_word_o.status == fbpa_pkg::ST_EMPTY ||
      out_word_o.status == fbpa_pkg::ST_NOT_ALLOC)
    else $error("undefined status code");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
